FILE: sv/iscf_pkg.sv
// Shared types and constants for the length-framed message checksum folder.
`timescale 1ns / 1ps
`default_nettype none

package iscf_pkg;

    localparam int WINDOW_DEF = 36;
    localparam int FIELD_SPAN = 36;
    localparam int ACC_COUNT  = 16;

    typedef logic [4:0] t_idx;

    localparam t_idx IDX_MSGS      = 5'd0;
    localparam t_idx IDX_ADDS      = 5'd1;
    localparam t_idx IDX_EXECS     = 5'd2;
    localparam t_idx IDX_CANCELS   = 5'd3;
    localparam t_idx IDX_DELETES   = 5'd4;
    localparam t_idx IDX_REPLACES  = 5'd5;
    localparam t_idx IDX_DIRS      = 5'd6;
    localparam t_idx IDX_SYSTEM    = 5'd7;
    localparam t_idx IDX_OTHERS    = 5'd8;
    localparam t_idx IDX_SHARES    = 5'd9;
    localparam t_idx IDX_PRICES    = 5'd10;
    localparam t_idx IDX_XOR_REF   = 5'd11;
    localparam t_idx IDX_XOR_MATCH = 5'd12;
    localparam t_idx IDX_XOR_NEW   = 5'd13;
    localparam t_idx IDX_XOR_STAMP = 5'd14;
    localparam t_idx IDX_MAX_LOC   = 5'd15;
    localparam t_idx IDX_CONSUMED  = 5'd16;

    localparam logic [7:0] MT_ADD       = 8'h41;  // 'A'
    localparam logic [7:0] MT_ADD_MPID  = 8'h46;  // 'F'
    localparam logic [7:0] MT_EXEC      = 8'h45;  // 'E'
    localparam logic [7:0] MT_EXEC_PX   = 8'h43;  // 'C'
    localparam logic [7:0] MT_CANCEL    = 8'h58;  // 'X'
    localparam logic [7:0] MT_DELETE    = 8'h44;  // 'D'
    localparam logic [7:0] MT_REPLACE   = 8'h55;  // 'U'
    localparam logic [7:0] MT_SYSTEM    = 8'h53;  // 'S'
    localparam logic [7:0] MT_DIRECTORY = 8'h52;  // 'R'
    localparam logic [7:0] FLAG_YES     = 8'h59;  // 'Y'

    typedef enum logic [1:0] {
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_HALT
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_beat;

    typedef struct packed {
        t_idx        counter_index;
        logic [63:0] counter_value;
        logic        last_of_run;
    } t_out_beat;

    typedef logic [FIELD_SPAN-1:0][7:0] t_span;

    // Per-message contribution to the accumulators
    typedef struct packed {
        t_idx        cnt_idx;
        logic [33:0] shares;
        logic [31:0] price;
        logic [63:0] xor_ref;
        logic [63:0] xor_match;
        logic [63:0] xor_new;
        logic [47:0] stamp;
        logic [15:0] locate;
        logic [16:0] consumed;
    } t_fold;

endpackage

`default_nettype wire

FILE: sv/iscf_decode.sv
// Message decoder: turns the body window of one message into accumulator deltas.
`timescale 1ns / 1ps
`default_nettype none

module iscf_decode
    import iscf_pkg::*;
(
    input  t_span       i_win,
    input  logic [15:0] i_len,
    output t_fold       o_fold
);

    always_comb begin
        t_fold      f;
        logic [7:0] mtype;
        mtype      = i_win[0];
        f          = '0;
        f.locate   = {i_win[1], i_win[2]};
        f.stamp    = {i_win[5], i_win[6], i_win[7], i_win[8], i_win[9], i_win[10]};
        f.consumed = 17'd2 + {1'b0, i_len};
        case (mtype)
            MT_ADD, MT_ADD_MPID: begin
                f.cnt_idx = IDX_ADDS;
                f.shares  = 34'({i_win[20], i_win[21], i_win[22], i_win[23]})
                          + 34'(i_win[19]) + 34'(mtype == MT_ADD_MPID);
                f.price   = {i_win[32], i_win[33], i_win[34], i_win[35]};
                f.xor_ref = {i_win[11], i_win[12], i_win[13], i_win[14],
                             i_win[15], i_win[16], i_win[17], i_win[18]};
            end
            MT_EXEC: begin
                f.cnt_idx   = IDX_EXECS;
                f.shares    = 34'({i_win[19], i_win[20], i_win[21], i_win[22]});
                f.xor_ref   = {i_win[11], i_win[12], i_win[13], i_win[14],
                               i_win[15], i_win[16], i_win[17], i_win[18]};
                f.xor_match = {i_win[23], i_win[24], i_win[25], i_win[26],
                               i_win[27], i_win[28], i_win[29], i_win[30]};
            end
            MT_EXEC_PX: begin
                f.cnt_idx   = IDX_EXECS;
                f.shares    = 34'({i_win[19], i_win[20], i_win[21], i_win[22]})
                            + 34'(i_win[31] == FLAG_YES);
                f.price     = {i_win[32], i_win[33], i_win[34], i_win[35]};
                f.xor_ref   = {i_win[11], i_win[12], i_win[13], i_win[14],
                               i_win[15], i_win[16], i_win[17], i_win[18]};
                f.xor_match = {i_win[23], i_win[24], i_win[25], i_win[26],
                               i_win[27], i_win[28], i_win[29], i_win[30]};
            end
            MT_CANCEL: begin
                f.cnt_idx = IDX_CANCELS;
                f.shares  = 34'({i_win[19], i_win[20], i_win[21], i_win[22]});
                f.xor_ref = {i_win[11], i_win[12], i_win[13], i_win[14],
                             i_win[15], i_win[16], i_win[17], i_win[18]};
            end
            MT_DELETE: begin
                f.cnt_idx = IDX_DELETES;
                f.xor_ref = {i_win[11], i_win[12], i_win[13], i_win[14],
                             i_win[15], i_win[16], i_win[17], i_win[18]};
            end
            MT_REPLACE: begin
                f.cnt_idx = IDX_REPLACES;
                f.shares  = 34'({i_win[27], i_win[28], i_win[29], i_win[30]});
                f.price   = {i_win[31], i_win[32], i_win[33], i_win[34]};
                f.xor_ref = {i_win[11], i_win[12], i_win[13], i_win[14],
                             i_win[15], i_win[16], i_win[17], i_win[18]};
                f.xor_new = {i_win[19], i_win[20], i_win[21], i_win[22],
                             i_win[23], i_win[24], i_win[25], i_win[26]};
            end
            MT_SYSTEM: begin
                f.cnt_idx = IDX_SYSTEM;
                f.shares  = 34'({i_win[3], i_win[4]}) + 34'(i_win[11]);
            end
            MT_DIRECTORY: begin
                f.cnt_idx = IDX_DIRS;
                f.shares  = 34'({i_win[21], i_win[22], i_win[23], i_win[24]});
            end
            default: begin
                // unknown type: no timestamp, no locate
                f.cnt_idx = IDX_OTHERS;
                f.shares  = 34'(mtype) + 34'(i_len);
                f.stamp   = '0;
                f.locate  = '0;
            end
        endcase
        o_fold = f;
    end

endmodule

`default_nettype wire

FILE: sv/itch_stream_checksum_folder.sv
// Top level: length-framed byte stream parser folding messages into 17 totals.
// Throughput: one byte per cycle while the input is not stalled.
// The first total of a run leaves once its end-of-buffer byte has passed the input and fold registers
// and loaded the totals bank; the 17 totals then leave one per cycle while the output is not stalled.
// Input stalls only when an end-of-buffer beat reaches the fold register while the previous run drains.
// Reset: synchronous, active low; clears parser state, accumulators and the output run.
`timescale 1ns / 1ps
`default_nettype none

module itch_stream_checksum_folder
    import iscf_pkg::*;
#(
    parameter int WINDOW_BYTES = WINDOW_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    logic        hold;

    logic        r_in_valid;
    t_in_beat    r_in;

    t_phase      r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_win [WINDOW_BYTES];
    logic [7:0]  n_win [WINDOW_BYTES];
    logic [15:0] pos_inc;
    logic        body_done;
    t_span       span;
    t_fold       fold_c;

    logic        r_f_valid, r_f_apply, r_f_eob;
    t_fold       r_f;

    logic [63:0] r_acc [ACC_COUNT+1];
    logic [63:0] n_acc [ACC_COUNT+1];

    logic        r_busy;
    t_idx        r_idx;
    logic [63:0] r_bank [ACC_COUNT+1];

    // a finished buffer waits while the previous run is still draining
    assign hold       = r_f_valid && r_f_eob && r_busy;
    assign o_in_stall = hold;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!hold) begin
            r_in_valid <= i_in_valid;
        end
        if (!hold) begin
            r_in <= i_in_beat;
        end
    end

    // parser
    assign pos_inc   = r_pos + 16'd1;
    assign body_done = pos_inc >= r_len;

    always_comb begin
        n_phase = r_phase;
        if (r_in_valid && !hold) begin
            if (r_in.end_of_buffer) begin
                n_phase = PH_LEN_HI;
            end else begin
                case (r_phase)
                    PH_LEN_HI: n_phase = PH_LEN_LO;
                    PH_LEN_LO: n_phase = ({r_len[15:8], r_in.data_byte} == 16'd0) ?
                                         PH_HALT : PH_BODY;
                    PH_BODY: begin
                        if (body_done) begin
                            n_phase = PH_LEN_HI;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    always_comb begin
        n_len = r_len;
        n_pos = r_pos;
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            n_win[i] = r_win[i];
        end
        if (r_in_valid && !hold) begin
            case (r_phase)
                PH_LEN_HI: n_len = {r_in.data_byte, 8'h00};
                PH_LEN_LO: begin
                    n_len = {r_len[15:8], r_in.data_byte};
                    n_pos = '0;
                    for (int i = 0; i < WINDOW_BYTES; i++) begin
                        n_win[i] = '0;
                    end
                end
                PH_BODY: begin
                    for (int i = 0; i < WINDOW_BYTES; i++) begin
                        if (r_pos == 16'(i)) begin
                            n_win[i] = r_in.data_byte;
                        end
                    end
                    n_pos = pos_inc;
                end
                default: n_pos = r_pos;
            endcase
            if (r_in.end_of_buffer) begin
                n_len = '0;
                n_pos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LEN_HI;
            r_len   <= '0;
            r_pos   <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
        end
        for (int i = 0; i < WINDOW_BYTES; i++) begin
            r_win[i] <= n_win[i];
        end
    end

    // window with the byte in flight merged in; bytes past the length are still zero
    always_comb begin
        for (int i = 0; i < FIELD_SPAN; i++) begin
            span[i] = (r_phase == PH_BODY && r_pos == 16'(i)) ? r_in.data_byte : r_win[i];
        end
    end

    iscf_decode u_decode (
        .i_win  (span),
        .i_len  (r_len),
        .o_fold (fold_c)
    );

    // fold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
            r_f_apply <= 1'b0;
            r_f_eob   <= 1'b0;
        end else if (!hold) begin
            r_f_valid <= r_in_valid;
            r_f_apply <= r_in_valid && (r_phase == PH_BODY) && body_done;
            r_f_eob   <= r_in_valid && r_in.end_of_buffer;
        end
        if (!hold) begin
            r_f <= fold_c;
        end
    end

    // accumulators
    always_comb begin
        for (int k = 0; k <= ACC_COUNT; k++) begin
            n_acc[k] = r_acc[k];
        end
        if (r_f_apply) begin
            for (int k = 0; k <= ACC_COUNT; k++) begin
                if (r_f.cnt_idx == t_idx'(k)) begin
                    n_acc[k] = r_acc[k] + 64'd1;
                end
            end
            n_acc[IDX_MSGS]      = r_acc[IDX_MSGS] + 64'd1;
            n_acc[IDX_SHARES]    = r_acc[IDX_SHARES] + 64'(r_f.shares);
            n_acc[IDX_PRICES]    = r_acc[IDX_PRICES] + 64'(r_f.price);
            n_acc[IDX_XOR_REF]   = r_acc[IDX_XOR_REF] ^ r_f.xor_ref;
            n_acc[IDX_XOR_MATCH] = r_acc[IDX_XOR_MATCH] ^ r_f.xor_match;
            n_acc[IDX_XOR_NEW]   = r_acc[IDX_XOR_NEW] ^ r_f.xor_new;
            n_acc[IDX_XOR_STAMP] = r_acc[IDX_XOR_STAMP] ^ 64'(r_f.stamp);
            if (64'(r_f.locate) > r_acc[IDX_MAX_LOC]) begin
                n_acc[IDX_MAX_LOC] = 64'(r_f.locate);
            end
            n_acc[IDX_CONSUMED]  = r_acc[IDX_CONSUMED] + 64'(r_f.consumed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= ACC_COUNT; k++) begin
                r_acc[k] <= '0;
            end
        end else if (r_f_valid && !hold) begin
            for (int k = 0; k <= ACC_COUNT; k++) begin
                r_acc[k] <= r_f_eob ? 64'd0 : n_acc[k];
            end
        end
    end

    // totals bank, shifted out one beat at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= IDX_MSGS;
        end else if (r_f_valid && r_f_eob && !r_busy) begin
            r_busy <= 1'b1;
            r_idx  <= IDX_MSGS;
        end else if (r_busy && !i_out_stall) begin
            r_idx <= r_idx + 5'd1;
            if (r_idx == IDX_CONSUMED) begin
                r_busy <= 1'b0;
            end
        end
        if (r_f_valid && r_f_eob && !r_busy) begin
            for (int k = 0; k <= ACC_COUNT; k++) begin
                r_bank[k] <= n_acc[k];
            end
        end else if (r_busy && !i_out_stall) begin
            for (int k = 0; k < ACC_COUNT; k++) begin
                r_bank[k] <= r_bank[k+1];
            end
        end
    end

    assign o_out_valid              = r_busy;
    assign o_out_beat.counter_index = r_idx;
    assign o_out_beat.counter_value = r_bank[0];
    assign o_out_beat.last_of_run   = (r_idx == IDX_CONSUMED);

endmodule

`default_nettype wire

FILE: sv/iscf_checker.sv
// Port-level checker for the totals output run, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module iscf_checker
    import iscf_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input t_out_beat o_out_beat
);

    a_last_matches_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_beat.last_of_run == (o_out_beat.counter_index == IDX_CONSUMED)))
        else $error("last_of_run does not mark the consumed total");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_beat.last_of_run) |=>
            (o_out_valid && o_out_beat.counter_index == $past(o_out_beat.counter_index) + 5'd1))
        else $error("totals run broke or skipped an index");

    a_run_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (o_out_beat.counter_index == IDX_MSGS))
        else $error("totals run did not start at the message count");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_beat.last_of_run) |=> !o_out_valid)
        else $error("new run began without a gap");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_beat)))
        else $error("stalled beat changed");

endmodule

bind itch_stream_checksum_folder iscf_checker u_iscf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_beat  (o_out_beat)
);

`default_nettype wire
